/* hdl/tefl_pkg.sv */
// Package: shared constants, codes and item types of the task event flag table.
`default_nettype none

package tefl_pkg;

  localparam int NUM_TASKS_DEF   = 32;
  localparam int EVENT_WIDTH_DEF = 32;

  localparam int OP_W     = 2;
  localparam int ID_W     = 6;
  localparam int EV_W     = 32;
  localparam int TICKS_W  = 32;
  localparam int STATUS_W = 4;

  localparam logic [TICKS_W-1:0] TICKS_FOREVER = '1;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_EXPIRE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 4'd0,
    ST_MASK_INV    = 4'd1,
    ST_FLAGS_INV   = 4'd2,
    ST_NOT_IN_TASK = 4'd3,
    ST_READ_FAIL   = 4'd4,
    ST_IN_LOCK     = 4'd5,
    ST_PENDING     = 4'd6,
    ST_TIMEOUT     = 4'd7,
    ST_ID_INV      = 4'd8,
    ST_EVENTS_INV  = 4'd9,
    ST_NOT_CREATED = 4'd10,
    ST_IGNORED     = 4'd11
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [ID_W-1:0]    task_id;
    logic [EV_W-1:0]    event_bits;
    logic               mode_all;
    logic               wait_req;
    logic [TICKS_W-1:0] timeout_ticks;
    logic               in_interrupt;
    logic               sched_locked;
    logic               task_created;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [EV_W-1:0]     events_out;
    logic                woken;
    logic                start_timer;
    logic [TICKS_W-1:0]  timer_ticks;
  } out_item_t;

  // Per-task wait flags, kept in flops.
  typedef struct packed {
    logic pend;
    logic timed;
  } task_flags_t;

  // Write enables from the evaluator to the state.
  typedef struct packed {
    logic entry_we;
    logic flag_we;
  } upd_t;

endpackage

`default_nettype wire

/* hdl/tefl_chan_if.sv */
// Interfaces: valid/ready channels for input and result words.
`default_nettype none

interface tefl_in_if import tefl_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tefl_out_if import tefl_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/task_event_flag_table_top.sv */
// Top level: task event flag table with entry memory, flags and result register.
//
//  channel  | dir | word        | accepted when
//  ---------+-----+-------------+-----------------------------
//  in_i     | in  | in_item_t   | in_i.valid  && in_i.ready
//  out_o    | out | out_item_t  | out_o.valid && out_o.ready
//
// One word per cycle sustained while the result is not stalled. A word is
// held in the input stage while the entry memory is read; its result is then
// registered in the result register, which drives out_o.valid and out_o.data.
// The entry memory has one read port, registered, and one write port; the
// last write is held aside and forwarded so back-to-back words to one task
// see each other. Reset clears the flags and the entry valid bits at once;
// an entry never written reads as zero, so no clearing pass is needed.
// A stalled result holds the input stage; input stays open while the result
// register can drain.
`default_nettype none

module task_event_flag_table_top import tefl_pkg::*; #(
  parameter int NUM_TASKS   = NUM_TASKS_DEF,
  parameter int EVENT_WIDTH = EVENT_WIDTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  tefl_in_if.sink     in_i,
  tefl_out_if.source  out_o
);

  localparam int IW    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int ENT_W = 2 * EVENT_WIDTH + 1;

  // Entry layout: {mode, mask, event word}.
  logic [ENT_W-1:0] mem [NUM_TASKS];
  logic [ENT_W-1:0] rd_q;

  logic [NUM_TASKS-1:0] ent_vld_q;
  logic [NUM_TASKS-1:0] pend_q;
  logic [NUM_TASKS-1:0] timed_q;

  // Input stage.
  logic     s1_vld_q;
  in_item_t s1_item_q;

  // Last write, for forwarding.
  logic             wb_vld_q;
  logic [IW-1:0]    wb_idx_q;
  logic [ENT_W-1:0] wb_q;

  // Result register.
  logic      out_vld_q;
  out_item_t out_item_q;

  logic accept;
  logic fire;

  logic [IW-1:0]    in_idx;
  logic [IW-1:0]    s1_idx;
  logic [ENT_W-1:0] ent;
  logic [ENT_W-1:0] ent_new;

  task_flags_t            flags_cur;
  task_flags_t            flags_new;
  upd_t                   upd;
  out_item_t              res;
  logic [EVENT_WIDTH-1:0] ev_new;
  logic [EVENT_WIDTH-1:0] mask_new;
  logic                   mode_new;

  // Handshake: advance the input stage whenever the result register can take it.
  assign fire        = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !s1_vld_q || fire;
  assign accept      = in_i.valid && in_i.ready;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_item_q;

  assign in_idx = in_i.data.task_id[IW-1:0];
  assign s1_idx = s1_item_q.task_id[IW-1:0];

  // Pick the freshest copy: last write, else memory, else the reset value.
  always_comb begin
    if (wb_vld_q && wb_idx_q == s1_idx) begin
      ent = wb_q;
    end else if (ent_vld_q[s1_idx]) begin
      ent = rd_q;
    end else begin
      ent = '0;
    end
  end

  assign flags_cur.pend  = pend_q[s1_idx];
  assign flags_cur.timed = timed_q[s1_idx];

  tefl_eval #(
    .NUM_TASKS   (NUM_TASKS),
    .EVENT_WIDTH (EVENT_WIDTH)
  ) u_eval (
    .item_i  (s1_item_q),
    .ev_i    (ent[EVENT_WIDTH-1:0]),
    .mask_i  (ent[2*EVENT_WIDTH-1:EVENT_WIDTH]),
    .mode_i  (ent[ENT_W-1]),
    .flags_i (flags_cur),
    .res_o   (res),
    .ev_o    (ev_new),
    .mask_o  (mask_new),
    .mode_o  (mode_new),
    .flags_o (flags_new),
    .upd_o   (upd)
  );

  assign ent_new = {mode_new, mask_new, ev_new};

  // Entry memory: read on accept, write when the input stage retires with an entry update.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= mem[in_idx];
    end
    if (fire && upd.entry_we) begin
      mem[s1_idx] <= ent_new;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_i.data;
    end
    if (fire) begin
      out_item_q <= res;
    end
    if (fire && upd.entry_we) begin
      wb_idx_q <= s1_idx;
      wb_q     <= ent_new;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      wb_vld_q  <= 1'b0;
      ent_vld_q <= '0;
      pend_q    <= '0;
      timed_q   <= '0;
    end else begin
      if (accept) begin
        s1_vld_q <= 1'b1;
      end else if (fire) begin
        s1_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (fire && upd.entry_we) begin
        wb_vld_q          <= 1'b1;
        ent_vld_q[s1_idx] <= 1'b1;
      end
      if (fire && upd.flag_we) begin
        pend_q[s1_idx]  <= flags_new.pend;
        timed_q[s1_idx] <= flags_new.timed;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // A timed wait is always a pending wait.
  a_timed_needs_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (timed_q & ~pend_q) == '0)
    else $error("timed flag set on a task that is not pending");

  // A woken reader is no longer pending afterwards.
  a_wake_clears_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res.woken) |=> !pend_q[$past(s1_idx)])
    else $error("woken task still pending");

  // A timer request only comes with a pending status.
  a_timer_with_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_item_q.start_timer) |-> (out_item_q.status == ST_PENDING))
    else $error("timer requested without pending status");
`endif

endmodule

`default_nettype wire

/* hdl/tefl_eval.sv */
// Evaluator: decides one operation against one task's entry and flags.
`default_nettype none

module tefl_eval import tefl_pkg::*; #(
  parameter int NUM_TASKS   = NUM_TASKS_DEF,
  parameter int EVENT_WIDTH = EVENT_WIDTH_DEF
) (
  input  in_item_t               item_i,
  input  logic [EVENT_WIDTH-1:0] ev_i,
  input  logic [EVENT_WIDTH-1:0] mask_i,
  input  logic                   mode_i,
  input  task_flags_t            flags_i,
  output out_item_t              res_o,
  output logic [EVENT_WIDTH-1:0] ev_o,
  output logic [EVENT_WIDTH-1:0] mask_o,
  output logic                   mode_o,
  output task_flags_t            flags_o,
  output upd_t                   upd_o
);

  localparam logic [ID_W:0] NumTasksW = (ID_W+1)'(NUM_TASKS);

  function automatic logic cond_holds(logic [EVENT_WIDTH-1:0] ev,
                                      logic [EVENT_WIDTH-1:0] mask, logic all);
    cond_holds = all ? ((ev & mask) == mask) : ((ev & mask) != '0);
  endfunction

  logic [EVENT_WIDTH-1:0] bits;
  logic [EVENT_WIDTH-1:0] ev_or;
  logic                   id_ok;
  logic                   timed_wait;

  assign bits       = item_i.event_bits[EVENT_WIDTH-1:0];
  assign ev_or      = ev_i | bits;
  assign id_ok      = {1'b0, item_i.task_id} < NumTasksW;
  assign timed_wait = item_i.timeout_ticks != TICKS_FOREVER;

  always_comb begin
    res_o.status      = ST_IGNORED;
    res_o.events_out  = '0;
    res_o.woken       = 1'b0;
    res_o.start_timer = 1'b0;
    res_o.timer_ticks = '0;
    ev_o              = ev_i;
    mask_o            = mask_i;
    mode_o            = mode_i;
    flags_o           = flags_i;
    upd_o.entry_we    = 1'b0;
    upd_o.flag_we     = 1'b0;

    case (op_e'(item_i.opcode))
      OP_READ: begin
        if (bits == '0) begin
          res_o.status = ST_MASK_INV;
        end else if (item_i.wait_req && item_i.timeout_ticks == '0) begin
          res_o.status = ST_FLAGS_INV;
        end else if (item_i.in_interrupt) begin
          res_o.status = ST_NOT_IN_TASK;
        end else if (!id_ok) begin
          res_o.status = ST_ID_INV;
        end else if (flags_i.pend) begin
          res_o.status = ST_IGNORED;
        end else begin
          upd_o.entry_we = 1'b1;
          mask_o         = bits;
          mode_o         = item_i.mode_all;
          if (cond_holds(ev_i, bits, item_i.mode_all)) begin
            res_o.events_out = EV_W'(ev_i & bits);
            ev_o             = ev_i & ~bits;
            res_o.status     = ST_OK;
          end else if (!item_i.wait_req) begin
            res_o.status = ST_READ_FAIL;
          end else if (item_i.sched_locked) begin
            res_o.status = ST_IN_LOCK;
          end else begin
            upd_o.flag_we     = 1'b1;
            flags_o.pend      = 1'b1;
            flags_o.timed     = timed_wait;
            res_o.start_timer = timed_wait;
            res_o.timer_ticks = timed_wait ? item_i.timeout_ticks : '0;
            res_o.status      = ST_PENDING;
          end
        end
      end
      OP_WRITE: begin
        if (!id_ok) begin
          res_o.status = ST_ID_INV;
        end else if (bits == '0) begin
          res_o.status = ST_EVENTS_INV;
        end else if (!item_i.task_created) begin
          res_o.status = ST_NOT_CREATED;
        end else begin
          upd_o.entry_we = 1'b1;
          res_o.status   = ST_OK;
          ev_o           = ev_or;
          // Consume the waiter's events now, not when it resumes.
          if (flags_i.pend && cond_holds(ev_or, mask_i, mode_i)) begin
            upd_o.flag_we    = 1'b1;
            flags_o.pend     = 1'b0;
            flags_o.timed    = 1'b0;
            res_o.woken      = 1'b1;
            res_o.events_out = EV_W'(ev_or & mask_i);
            ev_o             = ev_or & ~mask_i;
          end
        end
      end
      OP_EXPIRE: begin
        if (!id_ok) begin
          res_o.status = ST_ID_INV;
        end else if (flags_i.pend && flags_i.timed) begin
          upd_o.flag_we = 1'b1;
          flags_o.pend  = 1'b0;
          flags_o.timed = 1'b0;
          res_o.status  = ST_TIMEOUT;
        end else begin
          res_o.status = ST_IGNORED;
        end
      end
      default: begin
        res_o.status = ST_IGNORED;
      end
    endcase
  end

endmodule

`default_nettype wire

/* bench/tefl_flag_checker.sv */
// Checker: predicts event flag table results and compares them with the result channel.
`default_nettype none

module tefl_flag_checker import tefl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  tefl_in_if   in_mon_i,
  tefl_out_if  res_mon_i,
  output int   fail_count_o,
  output int   outstanding_o,
  output int   checked_o,
  output int   woken_o,
  output int   expired_o,
  output int   blocked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [EV_W-1:0] EV_KEEP = {EV_W{1'b1}} >> (EV_W - EVENT_WIDTH_DEF);

  // Shadow copy of the per-task table.
  logic [EV_W-1:0] event_word [NUM_TASKS_DEF];
  logic [EV_W-1:0] wait_mask  [NUM_TASKS_DEF];
  logic            wait_all   [NUM_TASKS_DEF];
  logic            blocked    [NUM_TASKS_DEF];
  logic            timed      [NUM_TASKS_DEF];

  out_item_t result_q [$];
  out_item_t want;

  function automatic bit wait_met(input logic [EV_W-1:0] ev, input logic [EV_W-1:0] mask,
                                  input logic all);
    return all ? ((ev & mask) == mask) : ((ev & mask) != '0);
  endfunction

  function automatic out_item_t predict_flag_op(input in_item_t w);
    out_item_t       r;
    logic [EV_W-1:0] bits;
    int unsigned     id;
    r        = '0;
    r.status = ST_IGNORED;
    bits     = w.event_bits & EV_KEEP;
    id       = 32'(w.task_id);
    case (w.opcode)
      OP_READ: begin
        if (bits == '0) begin
          r.status = ST_MASK_INV;
        end else if (w.wait_req && w.timeout_ticks == '0) begin
          r.status = ST_FLAGS_INV;
        end else if (w.in_interrupt) begin
          r.status = ST_NOT_IN_TASK;
        end else if (id >= NUM_TASKS_DEF) begin
          r.status = ST_ID_INV;
        end else if (blocked[id]) begin
          r.status = ST_IGNORED;
        end else begin
          wait_mask[id] = bits;
          wait_all[id]  = w.mode_all;
          if (wait_met(event_word[id], bits, w.mode_all)) begin
            r.events_out   = event_word[id] & bits;
            event_word[id] = event_word[id] & ~bits;
            r.status       = ST_OK;
          end else if (!w.wait_req) begin
            r.status = ST_READ_FAIL;
          end else if (w.sched_locked) begin
            r.status = ST_IN_LOCK;
          end else begin
            blocked[id] = 1'b1;
            timed[id]   = (w.timeout_ticks != TICKS_FOREVER);
            if (timed[id]) begin
              r.start_timer = 1'b1;
              r.timer_ticks = w.timeout_ticks;
            end
            r.status = ST_PENDING;
          end
        end
      end
      OP_WRITE: begin
        if (id >= NUM_TASKS_DEF) begin
          r.status = ST_ID_INV;
        end else if (bits == '0) begin
          r.status = ST_EVENTS_INV;
        end else if (!w.task_created) begin
          r.status = ST_NOT_CREATED;
        end else begin
          event_word[id] = event_word[id] | bits;
          r.status       = ST_OK;
          // wake the blocked reader and consume its events right here
          if (blocked[id] && wait_met(event_word[id], wait_mask[id], wait_all[id])) begin
            blocked[id]    = 1'b0;
            timed[id]      = 1'b0;
            r.woken        = 1'b1;
            r.events_out   = event_word[id] & wait_mask[id];
            event_word[id] = event_word[id] & ~wait_mask[id];
          end
        end
      end
      OP_EXPIRE: begin
        if (id >= NUM_TASKS_DEF) begin
          r.status = ST_ID_INV;
        end else if (blocked[id] && timed[id]) begin
          blocked[id] = 1'b0;
          timed[id]   = 1'b0;
          r.status    = ST_TIMEOUT;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic clear_state();
    foreach (event_word[i]) begin
      event_word[i] = '0;
      wait_mask[i]  = '0;
      wait_all[i]   = 1'b0;
      blocked[i]    = 1'b0;
      timed[i]      = 1'b0;
    end
    result_q.delete();
    fail_count_o  = 0;
    outstanding_o = 0;
    checked_o     = 0;
    woken_o       = 0;
    expired_o     = 0;
    blocked_o     = 0;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  initial clear_state();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
    end else begin
      if (res_mon_i.valid && res_mon_i.ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: result word with none expected, expected nothing, actual %h",
                   $time, res_mon_i.data);
          fail_count_o++;
        end else begin
          want = result_q.pop_front();
          check_field("status", 32'(want.status), 32'(res_mon_i.data.status));
          check_field("events_out", want.events_out, res_mon_i.data.events_out);
          check_field("woken", 32'(want.woken), 32'(res_mon_i.data.woken));
          check_field("start_timer", 32'(want.start_timer),
                      32'(res_mon_i.data.start_timer));
          check_field("timer_ticks", want.timer_ticks, res_mon_i.data.timer_ticks);
          checked_o++;
          if (want.woken) woken_o++;
          if (want.status == ST_TIMEOUT) expired_o++;
          if (want.status == ST_PENDING) blocked_o++;
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        result_q.push_back(predict_flag_op(in_mon_i.data));
      end
      outstanding_o = result_q.size();
    end
  end

endmodule

`default_nettype wire

/* bench/tb_task_event_flag_table_top.sv */
// Testbench top: clock, reset, word stimulus and verdict for the task event flag table.
`default_nettype none

module tb_task_event_flag_table_top import tefl_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              N_RANDOM    = 950;
  localparam int              DRAIN_EVERY = 300;
  // opcode with no operation behind it, must come back ignored
  localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;

  tefl_in_if  in_ch ();
  tefl_out_if res_ch ();

  int fail_count;
  int outstanding;
  int checked;
  int woken_cnt;
  int expired_cnt;
  int blocked_cnt;

  // receiver pattern state
  int stall_left = 0;
  int stall_mode = 0;
  int stall_cyc  = 0;

  always #1 clk_i = ~clk_i;

  task_event_flag_table_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (res_ch)
  );

  tefl_flag_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon_i      (in_ch),
    .res_mon_i     (res_ch),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .woken_o       (woken_cnt),
    .expired_o     (expired_cnt),
    .blocked_o     (blocked_cnt)
  );

  // Receiver: switch between stall patterns at random intervals. Mode 0 never
  // stalls, mode 1 stalls lightly, mode 2 is a coin toss, mode 3 holds off for
  // three quarters of each period so long back-pressure reaches the input stage.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 80);
    end
    stall_left--;
    stall_cyc++;
    case (stall_mode)
      0:       res_ch.ready <= 1'b1;
      1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
      2:       res_ch.ready <= 1'($urandom_range(0, 1));
      default: res_ch.ready <= ((stall_cyc % 16) >= 12);
    endcase
  end

  function automatic in_item_t make_word(input logic [OP_W-1:0] op, input int id,
                                         input logic [EV_W-1:0] bits, input logic all,
                                         input logic wt, input logic [TICKS_W-1:0] tmo,
                                         input logic intr, input logic lock,
                                         input logic created);
    in_item_t w;
    w.opcode        = op;
    w.task_id       = id[ID_W-1:0];
    w.event_bits    = bits;
    w.mode_all      = all;
    w.wait_req      = wt;
    w.timeout_ticks = tmo;
    w.in_interrupt  = intr;
    w.sched_locked  = lock;
    w.task_created  = created;
    return w;
  endfunction

  // Mostly legal operations on a few hot tasks so reads block, writes wake them
  // and expiries hit timed waits; the rest is bad ids, bad flags and noise.
  function automatic in_item_t random_op_word();
    logic [OP_W-1:0]    op;
    int                 id;
    int                 pick;
    logic [EV_W-1:0]    bits;
    logic [TICKS_W-1:0] tmo;
    pick = $urandom_range(0, 99);
    if (pick < 42)      op = OP_READ;
    else if (pick < 82) op = OP_WRITE;
    else if (pick < 96) op = OP_EXPIRE;
    else                op = OP_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 50)      id = $urandom_range(0, 7);
    else if (pick < 92) id = $urandom_range(0, NUM_TASKS_DEF - 1);
    else                id = $urandom_range(NUM_TASKS_DEF, 63);
    pick = $urandom_range(0, 99);
    if (pick < 40)      bits = $urandom_range(0, 15);
    else if (pick < 60) bits = 32'd1 << $urandom_range(0, EV_W - 1);
    else if (pick < 90) bits = $urandom;
    else if (pick < 95) bits = '0;
    else                bits = '1;
    pick = $urandom_range(0, 99);
    if (pick < 5)       tmo = '0;
    else if (pick < 25) tmo = TICKS_FOREVER;
    else if (pick < 35) tmo = $urandom_range(1, 100);
    else                tmo = $urandom;
    return make_word(op, id, bits, 1'($urandom_range(0, 1)), ($urandom_range(0, 99) < 65),
                     tmo, ($urandom_range(0, 99) < 5), ($urandom_range(0, 99) < 8),
                     ($urandom_range(0, 99) < 92));
  endfunction

  // Present one word and hold it until the block takes it.
  task automatic post_word(input in_item_t w);
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic rest_cycles(input int n);
    repeat (n) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
  endtask

  // Drop valid and hold off until every expected result has been checked.
  task automatic drain_results();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    wait (outstanding == 0);
  endtask

  initial begin
    int sent;
    int burst;
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    res_ch.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: every argument check, then block/wake/expire on a few tasks.
    post_word(make_word(OP_READ, 0, '0, 1'b0, 1'b1, 32'd10, 1'b0, 1'b0, 1'b1));
    post_word(make_word(OP_READ, 0, 32'd1, 1'b0, 1'b1, '0, 1'b0, 1'b0, 1'b1));
    post_word(make_word(OP_READ, 0, 32'd1, 1'b0, 1'b0, 32'd10, 1'b1, 1'b0, 1'b1));
    post_word(make_word(OP_READ, 63, 32'd1, 1'b0, 1'b0, 32'd10, 1'b0, 1'b0, 1'b1));
    post_word(make_word(OP_WRITE, 32, 32'd1, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b1));
    post_word(make_word(OP_WRITE, 0, '0, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b1));
    post_word(make_word(OP_WRITE, 0, 32'd1, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0));
    post_word(make_word(OP_EXPIRE, 40, '0, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b1));
    post_word(make_word(OP_EXPIRE, 3, '0, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b1));
    post_word(make_word(OP_UNUSED, 0, '1, 1'b1, 1'b1, '1, 1'b1, 1'b1, 1'b1));
    // unmatched read: fail without wait, then refused under the scheduler lock
    post_word(make_word(OP_READ, 0, 32'd1, 1'b0, 1'b0, 32'd10, 1'b0, 1'b0, 1'b1));
    post_word(make_word(OP_READ, 0, 32'd1, 1'b0, 1'b1, 32'd10, 1'b0, 1'b1, 1'b1));
    // wait forever for all events: no timer, second read and expiry ignored
    post_word(make_word(OP_READ, 1, '1, 1'b1, 1'b1, TICKS_FOREVER, 1'b0, 1'b0, 1'b1));
    post_word(make_word(OP_READ, 1, 32'd1, 1'b0, 1'b0, 32'd10, 1'b0, 1'b0, 1'b1));
    post_word(make_word(OP_EXPIRE, 1, '0, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b1));
    post_word(make_word(OP_WRITE, 1, 32'h0000_FFFF, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b1));
    post_word(make_word(OP_WRITE, 1, 32'hFFFF_0000, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b1));
    // timed wait on either the top or the bottom event bit: expire it, then wake the next one
    post_word(make_word(OP_READ, 2, 32'h8000_0001, 1'b0, 1'b1, 32'd1, 1'b0, 1'b0, 1'b1));
    post_word(make_word(OP_EXPIRE, 2, '0, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b1));
    post_word(make_word(OP_READ, 2, 32'h8000_0001, 1'b0, 1'b1, 32'hFFFF_FFFE, 1'b0, 1'b0,
                        1'b1));
    post_word(make_word(OP_WRITE, 2, 32'h8000_0000, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b1));
    // immediate reads consume only the masked part of the last task's word
    post_word(make_word(OP_WRITE, 31, '1, 1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b1));
    post_word(make_word(OP_READ, 31, 32'hA5A5_A5A5, 1'b0, 1'b0, 32'd10, 1'b0, 1'b0, 1'b1));
    post_word(make_word(OP_READ, 31, 32'h5A5A_5A5A, 1'b1, 1'b0, 32'd10, 1'b0, 1'b0, 1'b1));
    post_word(make_word(OP_READ, 31, '1, 1'b0, 1'b0, 32'd10, 1'b0, 1'b0, 1'b1));
    drain_results();

    // Random: bursts of words with gaps, draining now and then.
    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        post_word(random_op_word());
        sent++;
        if (sent % DRAIN_EVERY == 0) drain_results();
      end
      if ($urandom_range(0, 3) != 0) rest_cycles($urandom_range(1, 6));
    end

    drain_results();
    repeat (6) @(posedge clk_i);

    $display("covered %0d result words: %0d blocked reads, %0d woken readers, %0d timeouts",
             checked, blocked_cnt, woken_cnt, expired_cnt);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

/* task_event_flag_table_top.f */
hdl/tefl_pkg.sv
hdl/tefl_chan_if.sv
hdl/tefl_eval.sv
hdl/task_event_flag_table_top.sv
bench/tefl_flag_checker.sv
bench/tb_task_event_flag_table_top.sv
